// ===== rtl/four_way_merge_run_distributor_assert.svh =====
// ----------------------------------------------------------------------------
// four_way_merge_run_distributor_assert.svh
// Assertion macros used by the merge distributor checker.
// ----------------------------------------------------------------------------
`ifndef FOUR_WAY_MERGE_RUN_DISTRIBUTOR_ASSERT_SVH
`define FOUR_WAY_MERGE_RUN_DISTRIBUTOR_ASSERT_SVH

// same-cycle implication, off during reset
`define FWMRD_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication, off during reset
`define FWMRD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

// next-cycle implication, always on
`define FWMRD_ASSERT_ALWAYS(name, clk, ante, cons) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== rtl/fwmrd_pkg.sv =====
// ----------------------------------------------------------------------------
// fwmrd_pkg
// Types and constants for the four-way merge run distributor.
// ----------------------------------------------------------------------------
package fwmrd_pkg;

    localparam int Ways   = 4;
    localparam int LaneW  = $clog2(Ways);
    localparam int ValueW = 32;
    localparam int DestW  = 2;

    typedef struct packed {
        logic [LaneW-1:0]         lane;
        logic signed [ValueW-1:0] value;
        logic                     exhausted;
    } in_item_t;

    typedef struct packed {
        logic signed [ValueW-1:0] out_value;
        logic [DestW-1:0]         dest_file;
        logic [LaneW-1:0]         refill_lane;
        logic                     done_res;
    } out_item_t;

endpackage

// ===== rtl/four_way_merge_run_distributor.sv =====
// ----------------------------------------------------------------------------
// four_way_merge_run_distributor
// One pass of a 4-way merge: lane heads, minimum select, run distribution.
// ----------------------------------------------------------------------------
//  channel | ports                    | item
//  --------+--------------------------+-------------------------------------
//  input   | s_valid s_ready s_data   | lane head value or exhausted mark
//  result  | m_valid m_ready m_data   | smallest head, dest file, or done
//
//  One item per cycle while s_ready is high: head update, 4-lane
//  minimum and destination step are done in the accept cycle and land
//  in the result register, or in the skid register under stall.
//  A skid register holds one result under stall; s_ready drops only while
//  it is full.
//  aresetn (synchronous) clears lane flags, destination and result valids.
// ----------------------------------------------------------------------------
module four_way_merge_run_distributor
    import fwmrd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic signed [ValueW-1:0] head_reg [Ways];
    logic [Ways-1:0]          present_reg, present_next;
    logic [Ways-1:0]          finished_reg, finished_next;
    logic signed [ValueW-1:0] last_reg, last_next;
    logic [DestW-1:0]         dest_reg, dest_next;
    logic                     first_reg, first_next;

    out_item_t main_reg, skid_reg;
    logic      main_valid_reg, skid_valid_reg;

    logic                     s_fire, pop, push;
    logic [Ways-1:0]          lane_bit, pres_w, fin_w;
    logic signed [ValueW-1:0] heads_w [Ways];
    logic [LaneW-1:0]         best;
    logic                     best_found;
    logic signed [ValueW-1:0] best_val;
    out_item_t                res;

    assign s_ready = !skid_valid_reg;
    assign s_fire  = s_valid && s_ready;
    assign pop     = main_valid_reg && m_ready;
    assign m_valid = main_valid_reg;
    assign m_data  = main_reg;

    always_comb begin
        lane_bit = '0;
        lane_bit[s_data.lane] = 1'b1;
        for (int i = 0; i < Ways; i++) begin
            heads_w[i] = head_reg[i];
        end
        if (s_data.exhausted) begin
            fin_w  = finished_reg | lane_bit;
            pres_w = present_reg & ~lane_bit;
        end else begin
            fin_w  = finished_reg & ~lane_bit;
            pres_w = present_reg | lane_bit;
            heads_w[s_data.lane] = s_data.value;
        end

        best       = '0;
        best_found = 1'b0;
        best_val   = heads_w[0];
        for (int i = 0; i < Ways; i++) begin
            if (pres_w[i] && (!best_found || heads_w[i] < best_val)) begin
                best       = LaneW'(i);
                best_val   = heads_w[i];
                best_found = 1'b1;
            end
        end

        present_next  = present_reg;
        finished_next = finished_reg;
        last_next     = last_reg;
        dest_next     = dest_reg;
        first_next    = first_reg;
        push          = 1'b0;
        res           = '0;

        if (s_fire) begin
            present_next  = pres_w;
            finished_next = fin_w;
            if (&(pres_w | fin_w)) begin
                if (&fin_w) begin
                    push          = 1'b1;
                    res.done_res  = 1'b1;
                    present_next  = '0;
                    finished_next = '0;
                    last_next     = '0;
                    dest_next     = '0;
                    first_next    = 1'b1;
                end else if (best_found) begin
                    push = 1'b1;
                    if (first_reg) begin
                        dest_next  = '0;
                        first_next = 1'b0;
                    end else if (best_val < last_reg) begin
                        dest_next = dest_reg + DestW'(1);
                    end
                    last_next          = best_val;
                    present_next[best] = 1'b0;
                    res.out_value      = best_val;
                    res.dest_file      = dest_next;
                    res.refill_lane    = best;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && !s_data.exhausted) begin
            head_reg[s_data.lane] <= s_data.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg  <= '0;
            finished_reg <= '0;
            last_reg     <= '0;
            dest_reg     <= '0;
            first_reg    <= 1'b1;
        end else begin
            present_reg  <= present_next;
            finished_reg <= finished_next;
            last_reg     <= last_next;
            dest_reg     <= dest_next;
            first_reg    <= first_next;
        end
    end

    // result register with one-entry skid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                main_reg       <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_reg       <= res;
                main_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= res;
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

endmodule

// ===== rtl/fwmrd_checker.sv =====
// ----------------------------------------------------------------------------
// fwmrd_checker
// Port-level checks for the four-way merge run distributor.
// ----------------------------------------------------------------------------
`include "four_way_merge_run_distributor_assert.svh"

module fwmrd_checker
    import fwmrd_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    logic s_stall, m_stall, done_zero;

    assign s_stall   = s_valid && !s_ready;
    assign m_stall   = m_valid && !m_ready;
    assign done_zero = m_data.out_value == '0 && m_data.dest_file == '0
                       && m_data.refill_lane == '0;

    `FWMRD_ASSERT_NOW(a_done_zero, aclk, aresetn, m_valid && m_data.done_res, done_zero)
    `FWMRD_ASSERT_NOW(a_stall_needs_result, aclk, aresetn, !s_ready, m_valid)
    `FWMRD_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_stall, m_valid && $stable(m_data))
    `FWMRD_ASSERT_NEXT(a_input_holds, aclk, aresetn, s_stall, s_valid && $stable(s_data))
    `FWMRD_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn, !m_valid && s_ready)

endmodule

bind four_way_merge_run_distributor fwmrd_checker u_fwmrd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for the four-way merge run distributor.
//
// Items are driven on the s_ channel and the block's results are taken from
// the m_ channel, with random gaps on the input side and random holds on
// the output side. A predictor tracks the lane heads, the exhausted flags
// and the destination state. It queues the result that each accepted item
// should cause, and every result is checked field by field against the
// oldest entry in that queue. Stimulus comes in three parts: directed
// corner cases, random noise items, and random merge passes that refill
// the lanes the block consumes.
// ----------------------------------------------------------------------------
module tb;
    import fwmrd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic signed [ValueW-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [ValueW-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [ValueW-1:0] VAL_JUNK = 32'shdead_beef;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    // predictor state
    logic signed [ValueW-1:0] head_val [Ways];
    logic [Ways-1:0]          head_valid;
    logic [Ways-1:0]          lane_done;
    logic signed [ValueW-1:0] last_out;
    logic [DestW-1:0]         dest_idx;
    logic                     first_out;

    out_item_t expected_results [$];
    int        errors = 0;
    int        hold_cnt = 0;
    bit        in_idle_on = 1'b1;
    bit        out_idle_on = 1'b1;

    four_way_merge_run_distributor i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    initial begin
        #2ms;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic clear_merge_state();
        head_valid = '0;
        lane_done  = '0;
        last_out   = '0;
        dest_idx   = '0;
        first_out  = 1'b1;
    endtask

    task automatic merge_predict(input in_item_t it);
        logic [Ways-1:0] all_lanes;
        out_item_t       r;
        int              best;
        all_lanes = '1;
        if (it.lane >= Ways) return;
        if (it.exhausted) begin
            lane_done[it.lane]  = 1'b1;
            head_valid[it.lane] = 1'b0;
        end else begin
            head_val[it.lane]   = it.value;
            head_valid[it.lane] = 1'b1;
            lane_done[it.lane]  = 1'b0;
        end
        if ((head_valid | lane_done) != all_lanes) return;
        r = '0;
        if (lane_done == all_lanes) begin
            r.done_res = 1'b1;
            expected_results = {expected_results, r};
            clear_merge_state();
            return;
        end
        best = -1;
        for (int i = 0; i < Ways; i++) begin
            if (head_valid[i] && (best < 0 || head_val[i] < head_val[best])) best = i;
        end
        if (best < 0) return;
        if (first_out) begin
            dest_idx  = '0;
            first_out = 1'b0;
        end else if (head_val[best] < last_out) begin
            dest_idx = dest_idx + 1'b1;
        end
        last_out          = head_val[best];
        head_valid[best]  = 1'b0;
        r.out_value       = head_val[best];
        r.dest_file       = dest_idx;
        r.refill_lane     = LaneW'(best);
        expected_results = {expected_results, r};
    endtask

    task automatic send_item(input in_item_t it);
        int gap;
        gap = in_idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        merge_predict(it);
    endtask

    function automatic in_item_t lane_item(input int lane, input logic signed [ValueW-1:0] v,
                                           input bit exh);
        in_item_t it;
        it.lane      = LaneW'(lane);
        it.value     = v;
        it.exhausted = exh;
        return it;
    endfunction

    // result check and output-side holds
    always @(posedge aclk) begin
        out_item_t exp_r;
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_cnt = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: %p", m_data);
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_data.out_value !== exp_r.out_value) begin
                        $error("out_value: expected %0d, got %0d",
                               exp_r.out_value, m_data.out_value);
                        errors++;
                    end
                    if (m_data.dest_file !== exp_r.dest_file) begin
                        $error("dest_file: expected %0d, got %0d",
                               exp_r.dest_file, m_data.dest_file);
                        errors++;
                    end
                    if (m_data.refill_lane !== exp_r.refill_lane) begin
                        $error("refill_lane: expected %0d, got %0d",
                               exp_r.refill_lane, m_data.refill_lane);
                        errors++;
                    end
                    if (m_data.done_res !== exp_r.done_res) begin
                        $error("done_res: expected %0d, got %0d",
                               exp_r.done_res, m_data.done_res);
                        errors++;
                    end
                end
                hold_cnt = out_idle_on ? $urandom_range(0, 3) : 0;
            end
            if (hold_cnt > 0) begin
                m_ready <= 1'b0;
                hold_cnt--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic test_directed_cases();
        // extremes on all four lanes, min lands on dest 0
        send_item(lane_item(0, VAL_MAX, 1'b0));
        send_item(lane_item(1, VAL_MIN, 1'b0));
        send_item(lane_item(2, 0, 1'b0));
        send_item(lane_item(3, -1, 1'b0));
        send_item(lane_item(1, 5, 1'b0));
        // tie between lanes 2 and 3
        send_item(lane_item(3, 0, 1'b0));
        send_item(lane_item(2, VAL_JUNK, 1'b1));
        // head replaced while another lane is still missing
        send_item(lane_item(0, 7, 1'b0));
        send_item(lane_item(0, -5, 1'b0));
        send_item(lane_item(3, VAL_JUNK, 1'b1));
        // exhausted lane comes back
        send_item(lane_item(2, 3, 1'b0));
        send_item(lane_item(0, VAL_JUNK, 1'b1));
        // exhausted mark drops a held head, then all lanes done
        send_item(lane_item(1, VAL_JUNK, 1'b1));
        send_item(lane_item(2, VAL_JUNK, 1'b1));
        // descending single lane: destination wraps
        send_item(lane_item(1, -1, 1'b1));
        send_item(lane_item(2, -1, 1'b1));
        send_item(lane_item(3, -1, 1'b1));
        for (int v = 10; v >= 6; v--) send_item(lane_item(0, v, 1'b0));
        send_item(lane_item(0, 0, 1'b1));
    endtask

    task automatic test_noise_items(input int n_items);
        in_item_t it;
        in_idle_on  = 1'b0;
        out_idle_on = 1'b1;
        repeat (n_items) begin
            it.lane      = LaneW'($urandom);
            it.value     = $urandom;
            it.exhausted = $urandom_range(0, 3) == 0;
            send_item(it);
        end
    endtask

    task automatic test_merge_passes(input int n_items);
        int                       sent;
        int                       mode;
        int                       pick;
        int                       remaining [Ways];
        int                       missing [$];
        logic signed [ValueW-1:0] run_last [Ways];
        in_item_t                 it;
        sent = 0;
        while (sent < n_items) begin
            mode        = $urandom_range(0, 2);
            in_idle_on  = $urandom_range(0, 3) != 0;
            out_idle_on = $urandom_range(0, 3) != 0;
            for (int l = 0; l < Ways; l++) begin
                remaining[l] = $urandom_range(0, 12);
                run_last[l]  = $urandom;
            end
            // a pass ends once every lane is missing and its run is used up
            while (sent < n_items) begin
                missing.delete();
                for (int l = 0; l < Ways; l++) begin
                    if (!head_valid[l] && !lane_done[l]) missing = {missing, l};
                end
                if (missing.size() == Ways && remaining.sum() == 0) break;
                if (missing.size() == 0 || $urandom_range(0, 11) == 0) begin
                    it.lane      = LaneW'($urandom);
                    it.value     = $urandom;
                    it.exhausted = 1'($urandom);
                end else begin
                    pick = missing[$urandom_range(0, missing.size() - 1)];
                    it.lane = LaneW'(pick);
                    if (remaining[pick] > 0) begin
                        remaining[pick]--;
                        case (mode)
                            0: run_last[pick] = $signed($urandom_range(0, 16)) - 8;
                            1: run_last[pick] = $urandom;
                            default: run_last[pick] = run_last[pick]
                                                      + $signed($urandom_range(0, 120)) - 20;
                        endcase
                        it.value     = run_last[pick];
                        it.exhausted = 1'b0;
                    end else begin
                        it.value     = $urandom;
                        it.exhausted = 1'b1;
                    end
                end
                send_item(it);
                sent++;
            end
        end
    endtask

    initial begin
        clear_merge_state();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_noise_items(60);
        test_merge_passes(540);

        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
